/* hw/rtl/umclp_pkg.sv */
// Package for the motor command line parser: sequencer and decode types,
// result kind codes, character constants and fixed-point scaling constants.
// No dependencies.
`default_nettype none
package umclp_pkg;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_CHAR = 7'b0000100,
      ST_PAD  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_FIN  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef enum logic [3:0] {
      MD_HEAD  = 4'b0001,
      MD_NUM   = 4'b0010,
      MD_GAINS = 4'b0100,
      MD_BAD   = 4'b1000
   } mode_type;

   localparam logic [2:0] KIND_STOP      = 3'd0;
   localparam logic [2:0] KIND_RPM       = 3'd1;
   localparam logic [2:0] KIND_DUTY      = 3'd2;
   localparam logic [2:0] KIND_PID_BOTH  = 3'd3;
   localparam logic [2:0] KIND_PID_LEFT  = 3'd4;
   localparam logic [2:0] KIND_PID_RIGHT = 3'd5;
   localparam logic [2:0] KIND_ERROR     = 3'd6;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;

   localparam logic [2:0]  DEC_DIGITS = 3'd5;

   // Q16.16 fraction: (f*2^16 + 50000) / 100000 == (f*2^11 + 1562) / 3125,
   // and the divide by 3125 is a multiply by ceil(2^40 / 3125), exact below 2^28.
   localparam int          FRAC_BITS  = 16;
   localparam logic [27:0] FRAC_ROUND = 28'd1562;
   localparam logic [28:0] FRAC_RECIP = 29'd351843721;

endpackage
`default_nettype wire

/* hw/rtl/umclp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module umclp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/uart_motor_command_line_parser_core.sv */
// Top level of the motor command line parser: line store, decode sequencer
// and reciprocal fraction scaler. Depends on umclp_pkg and umclp_ram.
//
// Bytes 0x20 and up are stored in the line store. A CR or LF on a
// non-empty line starts a decode that reads the line store one byte at a
// time, then converts each number by padding the fraction to five digits,
// a setup step, a reciprocal multiply and a combine step. The input is
// not ready during a decode or while a result waits for the output
// register to free up.
`default_nettype none
module uart_motor_command_line_parser_core #(
   parameter int LINE_DEPTH  = 32,
   parameter int FIELD_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // rx_byte[7:0], time_ms[39:8]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [127:0] rsp_tdata,   // value_a, value_b, value_c, motion_time_ms
   output logic      [2:0]   rsp_tuser    // result_kind
);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int FW = $clog2(FIELD_DEPTH);
   localparam int SW = 33 + umclp_pkg::FRAC_BITS;
   localparam logic [1:0] NS_START = 2'd0;
   localparam logic [1:0] NS_INT   = 2'd1;
   localparam logic [1:0] NS_FRAC  = 2'd2;

   umclp_pkg::state_type state_ff, state_in;
   umclp_pkg::mode_type  mode_ff, mode_in;
   logic [2:0]  cmd_ff, cmd_in, res_ff, res_in;
   logic [7:0]  b0_ff, b0_in, b1_ff, b1_in;
   logic [2:0]  n_ff, n_in;
   logic        stop_ff, stop_in, last_ff, last_in;
   logic [AW-1:0] count_ff, count_in, len_ff, len_in, rd_ff, rd_in;
   logic [31:0] time_ff, time_in;
   logic [1:0]  vi_ff, vi_in, ns_ff, ns_in;
   logic [31:0] val_ff [3];
   logic [31:0] val_in [3];
   logic        minus_ff, minus_in, any_ff, any_in, rnd_ff, rnd_in;
   logic [31:0] ip_ff, ip_in;
   logic [16:0] f_ff, f_in;
   logic [2:0]  fc_ff, fc_in;
   logic [FW-1:0] flen_ff, flen_in;
   logic [27:0] dvd_ff, dvd_in;
   logic [umclp_pkg::FRAC_BITS:0] q_ff, q_in;
   logic        ov_ff, ov_in;
   logic [2:0]  ok_ff, ok_in;
   logic [31:0] oa_ff, oa_in, ob_ff, ob_in, oc_ff, oc_in, ot_ff, ot_in;

   logic        ram_we;
   logic [7:0]  ram_rdata, c, rx;
   logic        accept, is_dig;
   logic [3:0]  d;
   logic [35:0] ip10;
   logic [19:0] f10;
   logic [16:0] f_r;
   logic [56:0] prod;
   logic [SW-1:0] mag;
   logic [31:0] m32, sval;
   logic        sneg, pid, motion;

   umclp_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff),
      .wr_data (rx),
      .rd_addr (rd_ff),
      .rd_data (ram_rdata)
   );

   assign rx     = req_tdata[7:0];
   assign c      = ram_rdata;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == umclp_pkg::ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = {ot_ff, oc_ff, ob_ff, oa_ff};

   assign is_dig = (c >= umclp_pkg::CH_ZERO) && (c <= umclp_pkg::CH_NINE);
   assign d      = c[3:0];
   assign ip10   = {1'b0, ip_ff, 3'b000} + {3'b000, ip_ff, 1'b0} + {32'd0, d};
   assign f10    = {f_ff, 3'b000} + {2'b00, f_ff, 1'b0} + {16'd0, d};
   assign f_r    = f_ff + {16'd0, rnd_ff};
   assign prod   = 57'(dvd_ff) * 57'(umclp_pkg::FRAC_RECIP);
   assign mag    = {1'b0, ip_ff, {umclp_pkg::FRAC_BITS{1'b0}}} + SW'(q_ff);
   assign m32    = (mag[SW-1:31] != '0) ? 32'h7FFF_FFFF : mag[31:0];
   assign sneg   = minus_ff && (m32 != 32'd0);
   assign sval   = minus_ff ? (32'd0 - m32) : m32;
   assign pid    = (res_ff == umclp_pkg::KIND_PID_BOTH) || (res_ff == umclp_pkg::KIND_PID_LEFT)
                   || (res_ff == umclp_pkg::KIND_PID_RIGHT);
   assign motion = (res_ff == umclp_pkg::KIND_RPM) || (res_ff == umclp_pkg::KIND_DUTY);

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; cmd_in = cmd_ff; res_in = res_ff;
      b0_in = b0_ff; b1_in = b1_ff; n_in = n_ff; stop_in = stop_ff; last_in = last_ff;
      count_in = count_ff; len_in = len_ff; rd_in = rd_ff; time_in = time_ff;
      vi_in = vi_ff; ns_in = ns_ff;
      for (int i = 0; i < 3; i++) val_in[i] = val_ff[i];
      minus_in = minus_ff; any_in = any_ff; rnd_in = rnd_ff; ip_in = ip_ff;
      f_in = f_ff; fc_in = fc_ff; flen_in = flen_ff;
      dvd_in = dvd_ff; q_in = q_ff;
      ov_in = ov_ff; ok_in = ok_ff; oa_in = oa_ff; ob_in = ob_ff; oc_in = oc_ff;
      ot_in = ot_ff;
      ram_we = 1'b0;

      if (ov_ff && rsp_tready) ov_in = 1'b0;

      unique case (state_ff)
         umclp_pkg::ST_IDLE: begin
            if (accept) begin
               if (rx == umclp_pkg::CH_CR || rx == umclp_pkg::CH_LF) begin
                  if (count_ff != '0) begin
                     len_in = count_ff; count_in = '0; rd_in = '0;
                     mode_in = umclp_pkg::MD_HEAD; n_in = 3'd0; stop_in = 1'b1;
                     last_in = 1'b0; vi_in = 2'd0; time_in = req_tdata[39:8];
                     for (int i = 0; i < 3; i++) val_in[i] = 32'd0;
                     ns_in = NS_START; minus_in = 1'b0; any_in = 1'b0; rnd_in = 1'b0;
                     ip_in = 32'd0; f_in = 17'd0; fc_in = 3'd0; flen_in = '0;
                     state_in = umclp_pkg::ST_READ;
                  end
               end else if (count_ff >= AW'(LINE_DEPTH - 1)) begin
                  count_in = '0;
                  res_in   = umclp_pkg::KIND_ERROR;
                  state_in = umclp_pkg::ST_OUT;
               end else if (rx >= umclp_pkg::CH_SPACE) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + AW'(1);
               end
            end
         end
         umclp_pkg::ST_READ: begin
            if (rd_ff == len_ff) begin
               if (mode_ff == umclp_pkg::MD_BAD || mode_ff == umclp_pkg::MD_HEAD) begin
                  res_in = (stop_ff && n_ff == 3'd4) ? umclp_pkg::KIND_STOP
                                                     : umclp_pkg::KIND_ERROR;
                  state_in = umclp_pkg::ST_OUT;
               end else if (!last_ff) begin
                  last_in  = 1'b1;
                  state_in = umclp_pkg::ST_PAD;
               end else begin
                  res_in = (mode_ff == umclp_pkg::MD_NUM || vi_ff == 2'd3) ? cmd_ff
                                                                          : umclp_pkg::KIND_ERROR;
                  state_in = umclp_pkg::ST_OUT;
               end
            end else begin
               rd_in    = rd_ff + AW'(1);
               state_in = umclp_pkg::ST_CHAR;
            end
         end
         umclp_pkg::ST_CHAR: begin
            state_in = umclp_pkg::ST_READ;
            if (c != umclp_pkg::CH_SPACE) begin
               n_in = (n_ff == 3'd5) ? n_ff : n_ff + 3'd1;
               case (n_ff)
                  3'd0: stop_in = stop_ff && (c == umclp_pkg::CH_S);
                  3'd1: stop_in = stop_ff && (c == umclp_pkg::CH_T);
                  3'd2: stop_in = stop_ff && (c == umclp_pkg::CH_O);
                  3'd3: stop_in = stop_ff && (c == umclp_pkg::CH_P);
                  default: stop_in = 1'b0;
               endcase
               if (mode_ff == umclp_pkg::MD_HEAD) begin
                  if (n_ff == 3'd0) begin
                     b0_in = c;
                  end else if (n_ff == 3'd1) begin
                     b1_in = c;
                     if (c == umclp_pkg::CH_COMMA) begin
                        if (b0_ff == umclp_pkg::CH_M) begin
                           mode_in = umclp_pkg::MD_NUM; cmd_in = umclp_pkg::KIND_RPM;
                        end else if (b0_ff == umclp_pkg::CH_D) begin
                           mode_in = umclp_pkg::MD_NUM; cmd_in = umclp_pkg::KIND_DUTY;
                        end else if (b0_ff == umclp_pkg::CH_P) begin
                           mode_in = umclp_pkg::MD_GAINS; cmd_in = umclp_pkg::KIND_PID_BOTH;
                        end else begin
                           mode_in = umclp_pkg::MD_BAD;
                        end
                     end
                  end else begin
                     if (b0_ff == umclp_pkg::CH_P && c == umclp_pkg::CH_COMMA
                         && b1_ff == umclp_pkg::CH_L) begin
                        mode_in = umclp_pkg::MD_GAINS; cmd_in = umclp_pkg::KIND_PID_LEFT;
                     end else if (b0_ff == umclp_pkg::CH_P && c == umclp_pkg::CH_COMMA
                                  && b1_ff == umclp_pkg::CH_R) begin
                        mode_in = umclp_pkg::MD_GAINS; cmd_in = umclp_pkg::KIND_PID_RIGHT;
                     end else begin
                        mode_in = umclp_pkg::MD_BAD;
                     end
                  end
               end else if (mode_ff != umclp_pkg::MD_BAD) begin
                  if (c == umclp_pkg::CH_COMMA) begin
                     if (mode_ff == umclp_pkg::MD_GAINS && vi_ff != 2'd3) begin
                        state_in = umclp_pkg::ST_PAD;
                     end else begin
                        mode_in = umclp_pkg::MD_BAD;
                     end
                  end else if (mode_ff == umclp_pkg::MD_GAINS
                               && flen_ff >= FW'(FIELD_DEPTH - 1)) begin
                     mode_in = umclp_pkg::MD_BAD;
                  end else begin
                     if (mode_ff == umclp_pkg::MD_GAINS) flen_in = flen_ff + FW'(1);
                     if (ns_ff == NS_START && c == umclp_pkg::CH_MINUS) begin
                        minus_in = 1'b1; ns_in = NS_INT;
                     end else if (ns_ff == NS_START && c == umclp_pkg::CH_PLUS) begin
                        ns_in = NS_INT;
                     end else if (is_dig && ns_ff != NS_FRAC) begin
                        any_in = 1'b1; ns_in = NS_INT;
                        ip_in  = (ip10[35:32] != 4'd0) ? 32'hFFFF_FFFF : ip10[31:0];
                     end else if (c == umclp_pkg::CH_DOT && ns_ff != NS_FRAC) begin
                        ns_in = NS_FRAC;
                     end else if (is_dig) begin
                        any_in = 1'b1;
                        if (fc_ff < umclp_pkg::DEC_DIGITS) f_in = f10[16:0];
                        else if (fc_ff == umclp_pkg::DEC_DIGITS) rnd_in = (d >= 4'd5);
                        if (fc_ff <= umclp_pkg::DEC_DIGITS) fc_in = fc_ff + 3'd1;
                     end else begin
                        mode_in = umclp_pkg::MD_BAD;
                     end
                  end
               end
            end
         end
         umclp_pkg::ST_PAD: begin
            if (!any_ff) begin
               mode_in  = umclp_pkg::MD_BAD;
               state_in = umclp_pkg::ST_READ;
            end else if (fc_ff < umclp_pkg::DEC_DIGITS) begin
               f_in  = 17'({f_ff, 3'b000} + {2'b00, f_ff, 1'b0});
               fc_in = fc_ff + 3'd1;
            end else begin
               dvd_in   = {f_r, 11'd0} + umclp_pkg::FRAC_ROUND;
               state_in = umclp_pkg::ST_DIV;
            end
         end
         umclp_pkg::ST_DIV: begin
            q_in     = prod[56:40];
            state_in = umclp_pkg::ST_FIN;
         end
         umclp_pkg::ST_FIN: begin
            if (mode_ff == umclp_pkg::MD_GAINS && sneg) begin
               mode_in = umclp_pkg::MD_BAD;
            end else begin
               case (vi_ff)
                  2'd0: val_in[0] = sval;
                  2'd1: val_in[1] = sval;
                  default: val_in[2] = sval;
               endcase
            end
            vi_in = vi_ff + 2'd1;
            ns_in = NS_START; minus_in = 1'b0; any_in = 1'b0; rnd_in = 1'b0;
            ip_in = 32'd0; f_in = 17'd0; fc_in = 3'd0; flen_in = '0;
            state_in = umclp_pkg::ST_READ;
         end
         umclp_pkg::ST_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               ok_in = res_ff;
               oa_in = (pid || motion) ? val_ff[0] : 32'd0;
               ob_in = pid ? val_ff[1] : 32'd0;
               oc_in = pid ? val_ff[2] : 32'd0;
               ot_in = motion ? time_ff : 32'd0;
               state_in = umclp_pkg::ST_IDLE;
            end
         end
         default: state_in = umclp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= umclp_pkg::ST_IDLE;
         mode_ff  <= umclp_pkg::MD_HEAD;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
      cmd_ff <= cmd_in; res_ff <= res_in; b0_ff <= b0_in; b1_ff <= b1_in;
      n_ff <= n_in; stop_ff <= stop_in; last_ff <= last_in; len_ff <= len_in;
      rd_ff <= rd_in; time_ff <= time_in; vi_ff <= vi_in; ns_ff <= ns_in;
      for (int i = 0; i < 3; i++) val_ff[i] <= val_in[i];
      minus_ff <= minus_in; any_ff <= any_in; rnd_ff <= rnd_in; ip_ff <= ip_in;
      f_ff <= f_in; fc_ff <= fc_in; flen_ff <= flen_in;
      dvd_ff <= dvd_in; q_ff <= q_in;
      ok_ff <= ok_in; oa_ff <= oa_in; ob_ff <= ob_in; oc_ff <= oc_in; ot_ff <= ot_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= AW'(LINE_DEPTH - 1))
      else $error("fill count beyond line store");

   a_time_only_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != umclp_pkg::KIND_RPM && rsp_tuser != umclp_pkg::KIND_DUTY
      |-> rsp_tdata[127:96] == 32'd0)
      else $error("motion time on non-motion result");

   a_zero_values: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == umclp_pkg::KIND_STOP || rsp_tuser == umclp_pkg::KIND_ERROR)
      |-> rsp_tdata[95:0] == 96'd0)
      else $error("values on stop or error result");

   a_line_end_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (rx == umclp_pkg::CH_CR || rx == umclp_pkg::CH_LF) && count_ff != '0
      |=> state_ff == umclp_pkg::ST_READ && count_ff == '0)
      else $error("line end did not start decode");

endmodule
`default_nettype wire

/* dv/tb_uart_motor_command_line_parser_core.sv */
// Testbench for the motor command line parser core: drives byte items with
// random gaps, predicts each decoded command and checks every result item.
// Depends on umclp_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_uart_motor_command_line_parser_core;

   localparam int LINE_MAX  = 32;
   localparam int FIELD_MAX = 16;
   localparam int QBITS     = 16;
   localparam int WATCHDOG  = 20000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] va;
      logic [31:0] vb;
      logic [31:0] vc;
      logic [31:0] mtime;
   } cmd_type;

   typedef struct {
      logic [7:0] ch;
      logic       chk;
      cmd_type    want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic [2:0] rsp_tuser;

   uart_motor_command_line_parser_core dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   logic [7:0] line_buf[LINE_MAX];
   int line_len = 0;
   cmd_type cmd_queue[$];
   logic typed_pending[$];
   cmd_type typed_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit sending_done = 0;
   bit rsp_took = 0;
   int rsp_wait = 0;

   function automatic bit is_digit(logic [7:0] c);
      return c >= umclp_pkg::CH_ZERO && c <= umclp_pkg::CH_NINE;
   endfunction

   function automatic bit to_fixed(input logic [7:0] s[$], output logic [31:0] val,
                                   output bit neg);
      int i;
      int fcount;
      bit minus;
      bit any;
      bit rnd;
      longint unsigned ip;
      longint unsigned fr;
      longint unsigned mag;
      i = 0; fcount = 0; minus = 0; any = 0; rnd = 0; ip = 0; fr = 0;
      val = 0; neg = 0;
      if (i < s.size() && s[i] == umclp_pkg::CH_MINUS) begin
         minus = 1; i++;
      end else if (i < s.size() && s[i] == umclp_pkg::CH_PLUS) begin
         i++;
      end
      while (i < s.size() && is_digit(s[i])) begin
         any = 1;
         ip = ip * 10 + (s[i] - umclp_pkg::CH_ZERO);
         if (ip > 64'hFFFF_FFFF) ip = 64'hFFFF_FFFF;
         i++;
      end
      if (i < s.size() && s[i] == umclp_pkg::CH_DOT) begin
         i++;
         while (i < s.size() && is_digit(s[i])) begin
            any = 1;
            if (fcount < 5) fr = fr * 10 + (s[i] - umclp_pkg::CH_ZERO);
            else if (fcount == 5) rnd = (s[i] - umclp_pkg::CH_ZERO) >= 5;
            if (fcount <= 5) fcount++;
            i++;
         end
      end
      if (i != s.size() || !any) return 0;
      while (fcount < 5) begin
         fr *= 10; fcount++;
      end
      if (rnd) fr += 1;
      mag = (ip << QBITS) + ((fr << QBITS) + 50000) / 100000;
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      neg = minus && mag != 0;
      val = minus ? 32'(0 - mag) : 32'(mag);
      return 1;
   endfunction

   function automatic bit gains_ok(input logic [7:0] s[$], output logic [31:0] g[3]);
      logic [7:0] fld[$];
      bit neg[3];
      int vi;
      vi = 0; neg = '{0, 0, 0}; g = '{0, 0, 0};
      foreach (s[r]) begin
         if (s[r] == umclp_pkg::CH_COMMA) begin
            if (fld.size() == 0 || vi >= 3) return 0;
            if (!to_fixed(fld, g[vi], neg[vi])) return 0;
            vi++;
            fld = {};
         end else begin
            if (fld.size() >= FIELD_MAX - 1) return 0;
            fld.push_back(s[r]);
         end
      end
      if (fld.size() == 0 || vi != 2) return 0;
      if (!to_fixed(fld, g[2], neg[2])) return 0;
      return !(neg[0] || neg[1] || neg[2]);
   endfunction

   function automatic cmd_type decode_cmd(logic [31:0] t);
      logic [7:0] b[$];
      logic [31:0] g[3];
      bit neg;
      cmd_type c;
      c = '0;
      c.kind = umclp_pkg::KIND_ERROR;
      for (int r = 0; r < line_len; r++)
         if (line_buf[r] != umclp_pkg::CH_SPACE) b.push_back(line_buf[r]);
      if (b.size() == 4 && b[0] == umclp_pkg::CH_S && b[1] == umclp_pkg::CH_T
          && b[2] == umclp_pkg::CH_O && b[3] == umclp_pkg::CH_P) begin
         c.kind = umclp_pkg::KIND_STOP;
         return c;
      end
      if (b.size() >= 2 && b[1] == umclp_pkg::CH_COMMA) begin
         if ((b[0] == umclp_pkg::CH_M || b[0] == umclp_pkg::CH_D)
             && to_fixed(b[2:$], g[0], neg)) begin
            c.kind = (b[0] == umclp_pkg::CH_M) ? umclp_pkg::KIND_RPM : umclp_pkg::KIND_DUTY;
            c.va = g[0];
            c.mtime = t;
            return c;
         end
         if (b[0] == umclp_pkg::CH_P && gains_ok(b[2:$], g)) begin
            c.kind = umclp_pkg::KIND_PID_BOTH;
            c.va = g[0]; c.vb = g[1]; c.vc = g[2];
            return c;
         end
      end
      if (b.size() >= 3 && b[0] == umclp_pkg::CH_P && b[2] == umclp_pkg::CH_COMMA
          && (b[1] == umclp_pkg::CH_L || b[1] == umclp_pkg::CH_R) && gains_ok(b[3:$], g)) begin
         c.kind = (b[1] == umclp_pkg::CH_L) ? umclp_pkg::KIND_PID_LEFT
                                            : umclp_pkg::KIND_PID_RIGHT;
         c.va = g[0]; c.vb = g[1]; c.vc = g[2];
         return c;
      end
      return c;
   endfunction

   function automatic bit take_byte(logic [7:0] ch, logic [31:0] t, output cmd_type c);
      c = '0;
      if (ch == umclp_pkg::CH_CR || ch == umclp_pkg::CH_LF) begin
         if (line_len == 0) return 0;
         c = decode_cmd(t);
         line_len = 0;
         return 1;
      end
      if (line_len >= LINE_MAX - 1) begin
         line_len = 0;
         c.kind = umclp_pkg::KIND_ERROR;
         return 1;
      end
      if (ch >= umclp_pkg::CH_SPACE) begin
         line_buf[line_len] = ch;
         line_len++;
      end
      return 0;
   endfunction

   task automatic send_byte(logic [7:0] ch, bit chk = 0, cmd_type want = '0);
      logic [31:0] t;
      cmd_type c;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      t = $urandom;
      req_tvalid <= 1;
      req_tdata <= {t, ch};
      do @(posedge clock); while (!req_tready);
      if (take_byte(ch, t, c)) begin
         cmd_queue.push_back(c);
         typed_pending.push_back(chk);
         typed_queue.push_back(want);
      end
      @(negedge clock);
   endtask

   task automatic send_line(string s);
      foreach (s[i]) send_byte(s[i]);
      send_byte(($urandom_range(0, 1) != 0) ? umclp_pkg::CH_CR : umclp_pkg::CH_LF);
   endtask

   function automatic string rand_num(bit allow_neg);
      string s;
      int n;
      s = "";
      case ($urandom_range(0, 3))
         0: if (allow_neg) s = "-";
         1: s = "+";
         default: ;
      endcase
      n = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) n = 11;
      repeat (n) s = {s, string'(8'(umclp_pkg::CH_ZERO + $urandom_range(0, 9)))};
      if ($urandom_range(0, 1) != 0) begin
         s = {s, "."};
         repeat ($urandom_range(0, 7))
            s = {s, string'(8'(umclp_pkg::CH_ZERO + $urandom_range(0, 9)))};
      end
      if ($urandom_range(0, 15) == 0) s = {s, "x"};
      return s;
   endfunction

   function automatic string rand_cmd();
      string s;
      case ($urandom_range(0, 9))
         0: s = ($urandom_range(0, 3) != 0) ? "STOP" : "ST OP";
         1, 2: s = {"M,", rand_num(1)};
         3, 4: s = {"D, ", rand_num(1)};
         5, 6: s = {"P,", rand_num(0), ",", rand_num(0), ",", rand_num($urandom_range(0, 4) == 0)};
         7: s = {"PL,", rand_num(0), ",", rand_num(0), ",", rand_num(0)};
         8: s = {"PR,", rand_num(0), ",", rand_num(0), ",", rand_num(0)};
         default: begin
            s = "";
            repeat ($urandom_range(1, 10)) s = {s, string'(8'($urandom_range(32, 126)))};
         end
      endcase
      if (s.len() > LINE_MAX - 1) s = s.substr(0, LINE_MAX - 2);
      return s;
   endfunction

   localparam cmd_type ERR_CMD  = '{kind: umclp_pkg::KIND_ERROR, default: '0};
   localparam cmd_type STOP_CMD = '{kind: umclp_pkg::KIND_STOP, default: '0};

   initial begin
      row_type rows[$];
      string s;
      int i;
      rows.push_back('{umclp_pkg::CH_CR, 0, '0});
      s = "STOP";
      foreach (s[k]) rows.push_back('{s[k], 0, '0});
      rows.push_back('{umclp_pkg::CH_LF, 1, STOP_CMD});
      s = "stop";
      foreach (s[k]) rows.push_back('{s[k], 0, '0});
      rows.push_back('{8'h01, 0, '0});
      rows.push_back('{umclp_pkg::CH_CR, 1, ERR_CMD});
      s = "M,-1.5";
      foreach (s[k]) rows.push_back('{s[k], 0, '0});
      rows.push_back('{umclp_pkg::CH_CR, 0, '0});
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (rows[k]) send_byte(rows[k].ch, rows[k].chk, rows[k].want);
      send_line("D,99999999999.999995");
      send_line("P,0.000005,1.2,-0.000001");
      send_line("PL,1,2,-3");
      send_line("PR,123456789012345,0,0");
      send_line("P,1234567890123456,0,0");
      send_line("P,1,2");
      send_line("M,.");
      for (int k = 0; k < 31; k++) send_byte(8'hFF);
      send_byte(8'h80, 1, ERR_CMD);
      i = 0;
      while (i < 1490) begin
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 40)) begin
               send_byte(8'($urandom));
               i++;
            end
         end else begin
            s = rand_cmd();
            send_line(s);
            i += s.len() + 1;
         end
      end
      req_tvalid <= 0;
      sending_done = 1;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tready && rsp_took) begin
            rsp_wait = $urandom_range(0, 15);
            if (rsp_wait != 0) begin
               rsp_tready <= 0;
               rsp_wait = rsp_wait - 1;
            end
         end else if (!rsp_tready) begin
            if (rsp_wait == 0) rsp_tready <= 1;
            else rsp_wait = rsp_wait - 1;
         end
      end
   end

   always @(posedge clock) begin
      cmd_type got;
      cmd_type exp_cmd;
      bit typed;
      cmd_type typed_want;
      if (!reset) begin
         rsp_took <= rsp_tvalid && rsp_tready;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG) begin
            $display("uart_motor_command_line_parser_core: mismatch");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                   rsp_tdata[127:96]};
            if (cmd_queue.size() == 0) begin
               errors++;
               $display("%0t: expected no result actual %h", $time, got);
            end else begin
               exp_cmd = cmd_queue.pop_front();
               typed = typed_pending.pop_front();
               typed_want = typed_queue.pop_front();
               if (typed && typed_want != exp_cmd) begin
                  errors++;
                  $display("%0t: table expected %h, predictor %h", $time, typed_want, exp_cmd);
               end
               if (got.kind != exp_cmd.kind || got.va != exp_cmd.va || got.vb != exp_cmd.vb
                   || got.vc != exp_cmd.vc || got.mtime != exp_cmd.mtime) begin
                  errors++;
                  $display("%0t: expected %h actual %h", $time, exp_cmd, got);
               end
            end
         end
      end
   end

   initial begin
      wait (sending_done);
      while (cmd_queue.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0) $display("uart_motor_command_line_parser_core: match");
      else $display("uart_motor_command_line_parser_core: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
